// ===== rtl/fse_pkg.sv =====
// ---------------------------------------------------------------------------
// fse_pkg
// Types, codes and character tables shared by the format string expander.
// ---------------------------------------------------------------------------
package fse_pkg;

	// Width of the integer argument field and of one character.
	localparam int FSE_VALUE_W = 32;
	localparam int FSE_BYTE_W  = 8;

	// Reciprocal of ten for dividing a 32-bit value by multiply and shift.
	localparam logic [31:0] FSE_RECIP10      = 32'hCCCC_CCCD;
	localparam int          FSE_RECIP_SHIFT  = 35;

	// Input function codes.
	localparam logic [2:0] FUNC_FORMAT   = 3'd0;
	localparam logic [2:0] FUNC_INTEGER  = 3'd1;
	localparam logic [2:0] FUNC_STR_BYTE = 3'd2;
	localparam logic [2:0] FUNC_STR_END  = 3'd3;
	localparam logic [2:0] FUNC_STR_NULL = 3'd4;
	localparam logic [2:0] FUNC_FMT_END  = 3'd5;

	// Characters of interest in the format string.
	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_S       = 8'h73;
	localparam logic [7:0] CHAR_D       = 8'h64;
	localparam logic [7:0] CHAR_X       = 8'h78;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;

	// Number of characters in the null string text.
	localparam int NULL_LEN = 6;

	// Parse state of the front end.
	typedef enum logic [1:0] {
		MODE_LITERAL,
		MODE_PERCENT,
		MODE_STRING,
		MODE_INTEGER
	} fse_mode_t;

	// Kinds of work passed from the front end to the back end.
	typedef enum logic [2:0] {
		CMD_BYTE,
		CMD_NULL,
		CMD_DEC,
		CMD_HEX,
		CMD_REPORT
	} fse_kind_t;

	// One queued command.
	typedef struct packed {
		fse_kind_t               kind;
		logic [FSE_BYTE_W-1:0]   data;
		logic [FSE_VALUE_W-1:0]  value;
	} fse_cmd_t;

	// Queue status seen by its neighbours.
	typedef struct packed {
		logic full;
		logic empty;
	} fse_qstat_t;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		BACK_IDLE,
		BACK_NULLS,
		BACK_DEC_MUL,
		BACK_DEC_DIV,
		BACK_HEX,
		BACK_SIGN,
		BACK_DIGITS
	} fse_back_t;

	// Lowercase hex digit character.
	function automatic logic [7:0] fse_hex_char(input logic [3:0] d);
		logic [7:0] c;
		case (d)
			4'd10:   c = 8'h61;
			4'd11:   c = 8'h62;
			4'd12:   c = 8'h63;
			4'd13:   c = 8'h64;
			4'd14:   c = 8'h65;
			4'd15:   c = 8'h66;
			default: c = 8'h30 + {4'd0, d};
		endcase
		return c;
	endfunction

	// Characters of the text printed for a null string.
	function automatic logic [7:0] fse_null_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0:    c = 8'h28;
			3'd1:    c = 8'h6E;
			3'd2:    c = 8'h75;
			3'd3:    c = 8'h6C;
			3'd4:    c = 8'h6C;
			default: c = 8'h29;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/fse_front.sv =====
// ---------------------------------------------------------------------------
// fse_front
// Accepts input items, tracks the format parse state and turns each item
// into at most one command for the back end.
// ---------------------------------------------------------------------------
module fse_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   func,
	input  logic [7:0]                   data_byte,
	input  logic [31:0]                  int_value,
	input  fse_pkg::fse_qstat_t          qstat,
	output logic                         push,
	output fse_pkg::fse_cmd_t            cmd
);

	fse_pkg::fse_mode_t mode_q, mode_d;
	logic               hex_q, hex_d;
	logic               make_cmd;
	logic               accept;

	// An item is taken whenever the queue has room for its command.
	assign in_stall = qstat.full;
	assign accept   = in_valid && !qstat.full;
	assign push     = accept && make_cmd;

	// Classify the item against the current parse state.
	always_comb begin
		mode_d    = mode_q;
		hex_d     = hex_q;
		make_cmd  = 1'b0;
		cmd.kind  = fse_pkg::CMD_BYTE;
		cmd.data  = data_byte;
		cmd.value = int_value;
		case (func)
			fse_pkg::FUNC_FORMAT: begin
				if (mode_q == fse_pkg::MODE_PERCENT) begin
					case (data_byte)
						fse_pkg::CHAR_S: mode_d = fse_pkg::MODE_STRING;
						fse_pkg::CHAR_D: begin
							mode_d = fse_pkg::MODE_INTEGER;
							hex_d  = 1'b0;
						end
						fse_pkg::CHAR_X: begin
							mode_d = fse_pkg::MODE_INTEGER;
							hex_d  = 1'b1;
						end
						default: mode_d = fse_pkg::MODE_LITERAL;
					endcase
				end else if (data_byte == fse_pkg::CHAR_PERCENT) begin
					mode_d = fse_pkg::MODE_PERCENT;
				end else begin
					mode_d   = fse_pkg::MODE_LITERAL;
					make_cmd = 1'b1;
				end
			end
			fse_pkg::FUNC_INTEGER: begin
				if (mode_q == fse_pkg::MODE_INTEGER) begin
					make_cmd = 1'b1;
					cmd.kind = hex_q ? fse_pkg::CMD_HEX : fse_pkg::CMD_DEC;
					mode_d   = fse_pkg::MODE_LITERAL;
				end
			end
			fse_pkg::FUNC_STR_BYTE: begin
				if (mode_q == fse_pkg::MODE_STRING) begin
					make_cmd = 1'b1;
				end
			end
			fse_pkg::FUNC_STR_END: begin
				if (mode_q == fse_pkg::MODE_STRING) begin
					mode_d = fse_pkg::MODE_LITERAL;
				end
			end
			fse_pkg::FUNC_STR_NULL: begin
				if (mode_q == fse_pkg::MODE_STRING) begin
					make_cmd = 1'b1;
					cmd.kind = fse_pkg::CMD_NULL;
					mode_d   = fse_pkg::MODE_LITERAL;
				end
			end
			fse_pkg::FUNC_FMT_END: begin
				make_cmd = 1'b1;
				cmd.kind = fse_pkg::CMD_REPORT;
				mode_d   = fse_pkg::MODE_LITERAL;
				hex_d    = 1'b0;
			end
			default: begin
				make_cmd = 1'b0;
			end
		endcase
	end

	// Parse state advances only on an accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= fse_pkg::MODE_LITERAL;
			hex_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			hex_q  <= hex_d;
		end
	end

endmodule

// ===== rtl/fse_queue.sv =====
// ---------------------------------------------------------------------------
// fse_queue
// Short first-in first-out queue of commands between front and back end.
// ---------------------------------------------------------------------------
module fse_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fse_pkg::fse_cmd_t   wr_cmd,
	input  logic                pop,
	output fse_pkg::fse_cmd_t   rd_cmd,
	output fse_pkg::fse_qstat_t qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	fse_pkg::fse_cmd_t  entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign rd_cmd      = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/fse_back.sv =====
// ---------------------------------------------------------------------------
// fse_back
// Carries out queued commands: copies bytes, spells the null text, converts
// integers digit by digit and keeps the saturating byte count. Results leave
// through an output register.
// ---------------------------------------------------------------------------
module fse_back #(
	parameter int COUNT_BITS = 16,
	parameter int INT_BITS   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fse_pkg::fse_cmd_t   cmd,
	input  fse_pkg::fse_qstat_t qstat,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [7:0]          out_byte,
	output logic                out_valid,
	output logic                last,
	output logic [15:0]         byte_count
);

	localparam int MAX_DIGITS = INT_BITS / 3 + 1;
	localparam int DEPTH_W    = $clog2(MAX_DIGITS + 1);
	localparam int Q_W        = 64 - fse_pkg::FSE_RECIP_SHIFT;

	fse_pkg::fse_back_t  state_q, state_d;
	logic [INT_BITS-1:0] mag_q;
	logic                neg_q;
	logic [63:0]         prod_q;
	logic [3:0]          stack_q [MAX_DIGITS];
	logic [DEPTH_W-1:0]  depth_q;
	logic [2:0]          idx_q;
	logic [COUNT_BITS-1:0] total_q;

	logic [7:0]          obyte_q;
	logic                ovalid_q;
	logic                olast_q;
	logic [15:0]         ocount_q;
	logic                res_valid_q;

	logic                out_free;
	logic                emit_char;
	logic                emit_report;
	logic [7:0]          emit_byte;
	logic                emit_last;
	logic                load_arg;
	logic                stack_push;
	logic                stack_pop;
	logic [3:0]          push_digit;
	logic                do_mul;
	logic                mag_next_en;
	logic [INT_BITS-1:0] mag_next;
	logic                idx_clear;
	logic                idx_step;

	logic [INT_BITS-1:0] arg_raw;
	logic [INT_BITS-1:0] arg_mag;
	logic [Q_W-1:0]      quot;
	logic [31:0]         quot_x10;
	logic [31:0]         rem;
	logic [INT_BITS-1:0] hex_rest;
	logic [COUNT_BITS-1:0] total_inc;

	// Saturated view of the count on the 16-bit result field.
	function automatic logic [15:0] shown(input logic [COUNT_BITS-1:0] t);
		logic [31:0] w;
		w = 32'(t);
		return (w > 32'd65535) ? 16'hFFFF : w[15:0];
	endfunction

	assign out_free = !res_valid_q || !res_stall;

	// Argument magnitude and sign.
	assign arg_raw = cmd.value[INT_BITS-1:0];
	assign arg_mag = (cmd.kind == fse_pkg::CMD_DEC && arg_raw[INT_BITS-1])
		? (~arg_raw + INT_BITS'(1)) : arg_raw;

	// Decimal step: quotient from the registered product, remainder by subtraction.
	assign quot     = prod_q[63:fse_pkg::FSE_RECIP_SHIFT];
	assign quot_x10 = 32'({quot, 3'b000}) + 32'({quot, 1'b0});
	assign rem      = 32'(mag_q) - quot_x10;
	assign hex_rest = mag_q >> 4;

	assign total_inc = (total_q == '1) ? total_q : total_q + COUNT_BITS'(1);

	// Next state and sequencing controls.
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		emit_char   = 1'b0;
		emit_report = 1'b0;
		emit_byte   = cmd.data;
		emit_last   = 1'b1;
		load_arg    = 1'b0;
		stack_push  = 1'b0;
		stack_pop   = 1'b0;
		push_digit  = rem[3:0];
		do_mul      = 1'b0;
		mag_next_en = 1'b0;
		mag_next    = INT_BITS'(quot);
		idx_clear   = 1'b0;
		idx_step    = 1'b0;
		case (state_q)
			fse_pkg::BACK_IDLE: begin
				if (!qstat.empty) begin
					case (cmd.kind)
						fse_pkg::CMD_BYTE: begin
							if (out_free) begin
								pop       = 1'b1;
								emit_char = 1'b1;
							end
						end
						fse_pkg::CMD_REPORT: begin
							if (out_free) begin
								pop         = 1'b1;
								emit_report = 1'b1;
							end
						end
						fse_pkg::CMD_NULL: begin
							pop       = 1'b1;
							idx_clear = 1'b1;
							state_d   = fse_pkg::BACK_NULLS;
						end
						fse_pkg::CMD_DEC: begin
							pop      = 1'b1;
							load_arg = 1'b1;
							state_d  = fse_pkg::BACK_DEC_MUL;
						end
						fse_pkg::CMD_HEX: begin
							pop      = 1'b1;
							load_arg = 1'b1;
							state_d  = fse_pkg::BACK_HEX;
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			fse_pkg::BACK_NULLS: begin
				if (out_free) begin
					emit_char = 1'b1;
					emit_byte = fse_pkg::fse_null_char(idx_q);
					emit_last = (idx_q == 3'(fse_pkg::NULL_LEN - 1));
					idx_step  = 1'b1;
					if (emit_last) begin
						state_d = fse_pkg::BACK_IDLE;
					end
				end
			end
			fse_pkg::BACK_DEC_MUL: begin
				do_mul  = 1'b1;
				state_d = fse_pkg::BACK_DEC_DIV;
			end
			fse_pkg::BACK_DEC_DIV: begin
				stack_push  = 1'b1;
				mag_next_en = 1'b1;
				if (quot == '0) begin
					state_d = neg_q ? fse_pkg::BACK_SIGN : fse_pkg::BACK_DIGITS;
				end else begin
					state_d = fse_pkg::BACK_DEC_MUL;
				end
			end
			fse_pkg::BACK_HEX: begin
				stack_push  = 1'b1;
				push_digit  = mag_q[3:0];
				mag_next_en = 1'b1;
				mag_next    = hex_rest;
				if (hex_rest == '0) begin
					state_d = fse_pkg::BACK_DIGITS;
				end
			end
			fse_pkg::BACK_SIGN: begin
				if (out_free) begin
					emit_char = 1'b1;
					emit_byte = fse_pkg::CHAR_MINUS;
					emit_last = 1'b0;
					state_d   = fse_pkg::BACK_DIGITS;
				end
			end
			fse_pkg::BACK_DIGITS: begin
				if (out_free) begin
					emit_char = 1'b1;
					emit_byte = fse_pkg::fse_hex_char(stack_q[0]);
					emit_last = (depth_q == DEPTH_W'(1));
					stack_pop = 1'b1;
					if (emit_last) begin
						state_d = fse_pkg::BACK_IDLE;
					end
				end
			end
			default: begin
				state_d = fse_pkg::BACK_IDLE;
			end
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fse_pkg::BACK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Conversion datapath: magnitude, product and null text index.
	always_ff @(posedge clk) begin
		if (load_arg) begin
			mag_q <= arg_mag;
			neg_q <= (cmd.kind == fse_pkg::CMD_DEC) && arg_raw[INT_BITS-1];
		end else if (mag_next_en) begin
			mag_q <= mag_next;
		end
		if (do_mul) begin
			prod_q <= 64'(32'(mag_q)) * 64'(fse_pkg::FSE_RECIP10);
		end
		if (idx_clear) begin
			idx_q <= '0;
		end else if (idx_step) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	// Digit stack: the newest digit sits at the top and leaves first.
	always_ff @(posedge clk) begin
		if (stack_push) begin
			for (int i = MAX_DIGITS - 1; i > 0; i--) begin
				stack_q[i] <= stack_q[i-1];
			end
			stack_q[0] <= push_digit;
		end else if (stack_pop) begin
			for (int i = 0; i < MAX_DIGITS - 1; i++) begin
				stack_q[i] <= stack_q[i+1];
			end
		end
	end

	// Digit count of the stack.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (stack_push) begin
			depth_q <= depth_q + DEPTH_W'(1);
		end else if (stack_pop) begin
			depth_q <= depth_q - DEPTH_W'(1);
		end
	end

	// Running byte count, cleared by a report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (emit_char) begin
			total_q <= total_inc;
		end else if (emit_report) begin
			total_q <= '0;
		end
	end

	// Output register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_char || emit_report) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_char) begin
			obyte_q  <= emit_byte;
			ovalid_q <= 1'b1;
			olast_q  <= emit_last;
			ocount_q <= shown(total_inc);
		end else if (emit_report) begin
			obyte_q  <= 8'd0;
			ovalid_q <= 1'b0;
			olast_q  <= 1'b1;
			ocount_q <= shown(total_q);
		end
	end

	assign res_valid  = res_valid_q;
	assign out_byte   = obyte_q;
	assign out_valid  = ovalid_q;
	assign last       = olast_q;
	assign byte_count = ocount_q;

endmodule

// ===== rtl/format_string_expander_unit.sv =====
// ---------------------------------------------------------------------------
// format_string_expander_unit
// Minimal formatter for percent-s, percent-d and percent-x conversions.
// ---------------------------------------------------------------------------
// A result passes through the command queue and the output register after its
// item is accepted; literal and string bytes sustain one item per cycle while
// the back end is idle and the output is not stalled. A decimal integer goes
// through the multiply and divide states of the divide-by-ten step per digit,
// hex through a single state per digit; a null string spells its six characters.
// Reset clears parse state, byte count, queue and output valid at once.
module format_string_expander_unit #(
	parameter int COUNT_BITS  = 16,
	parameter int INT_BITS    = 32,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [7:0]  data_byte,
	input  logic [31:0] int_value,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        last,
	output logic [15:0] byte_count
);

	fse_pkg::fse_cmd_t   push_cmd;
	fse_pkg::fse_cmd_t   head_cmd;
	fse_pkg::fse_qstat_t qstat;
	logic                push;
	logic                pop;

	// Front end: parse state and classification.
	fse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.data_byte (data_byte),
		.int_value (int_value),
		.qstat     (qstat),
		.push      (push),
		.cmd       (push_cmd)
	);

	// Command queue between the two halves.
	fse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (push_cmd),
		.pop    (pop),
		.rd_cmd (head_cmd),
		.qstat  (qstat)
	);

	// Back end: execution and result register.
	fse_back #(
		.COUNT_BITS (COUNT_BITS),
		.INT_BITS   (INT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (head_cmd),
		.qstat      (qstat),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_byte   (out_byte),
		.out_valid  (out_valid),
		.last       (last),
		.byte_count (byte_count)
	);

endmodule

// ===== rtl/fse_checker.sv =====
// ---------------------------------------------------------------------------
// fse_checker
// Port-level checks on the result stream of the format string expander.
// ---------------------------------------------------------------------------
module fse_checker #(
	parameter int COUNT_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic [7:0]  out_byte,
	input logic        out_valid,
	input logic        last,
	input logic [15:0] byte_count
);

	localparam int SHOW_MAX = (COUNT_BITS >= 16) ? 65535 : ((1 << COUNT_BITS) - 1);

	logic res_take;
	assign res_take = res_valid && !res_stall;

	// A waiting result stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result withdrawn while stalled");

	// A waiting result keeps its character.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(out_byte) && $stable(last))
		else $error("result changed while stalled");

	// A count report carries no character and closes its item.
	a_report_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> last && (out_byte == 8'd0))
		else $error("malformed count report");

	// Characters taken back to back count up by one unless saturated.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(res_take && out_valid) ##1 (res_take && out_valid) |->
		(byte_count == 16'($past(byte_count) + 16'd1)) ||
		(byte_count == 16'(SHOW_MAX)))
		else $error("byte count did not advance by one");

endmodule

bind format_string_expander_unit fse_checker #(
	.COUNT_BITS (COUNT_BITS)
) u_fse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.out_byte   (out_byte),
	.out_valid  (out_valid),
	.last       (last),
	.byte_count (byte_count)
);
